// ----- rtl/core/lms_training_equalizer_unit_defines.svh -----
// Assertion macros shared by the checker.
`ifndef LMS_TRAINING_EQUALIZER_UNIT_DEFINES_SVH
`define LMS_TRAINING_EQUALIZER_UNIT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define LTE_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error("lte check failed");
// Next-cycle implication checked outside reset.
`define LTE_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error("lte check failed");
`endif

// ----- rtl/core/lte_pkg.sv -----
// ----------------------------------------------------------------------------
// lte_pkg
// Types and constants of the LMS training equalizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package lte_pkg;
  localparam int SegmentLength = 832;
  localparam int PosW = 10;
  localparam int Pn9Len = 511;
  localparam int Pn6Len = 63;
  localparam int LevelQ10 = 5120;

  // Seed windows of the two pseudo-noise generators; bit n holds element n.
  localparam logic [8:0] Pn9Init = 9'b0_1000_0000;
  localparam logic [5:0] Pn6Init = 6'b10_0111;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FIR, ST_FIRLAST, ST_UPD, ST_OUT
  } lte_state_e;

  typedef struct packed {
    logic clear_acc;  // start a new dot product at tap 0
    logic mac;        // accumulate one tap
    logic update;     // update one tap weight
    logic emit;       // load output register
  } lte_cmd_t;

  typedef struct packed {
    logic last_tap;
  } lte_sts_t;
endpackage

// ----- rtl/core/lte_stream_if.sv -----
// ----------------------------------------------------------------------------
// lte_stream_if
// Valid/ready channel with a generic payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface lte_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/lte_ctrl.sv -----
// ----------------------------------------------------------------------------
// lte_ctrl
// Sequencer: accept a word, optionally run the FIR, then either the LMS update or the emit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module lte_ctrl import lte_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       do_fir_i,
  input  logic       do_train_i,
  input  logic       do_emit_i,
  input  logic       out_free_i,
  input  lte_sts_t   sts_i,
  output lte_cmd_t   cmd_o,
  output logic       accept_o
);
  lte_state_e state_q, state_d;
  logic train_q, train_d, emit_q, emit_d;

  always_comb begin
    state_d = state_q;
    train_d = train_q;
    emit_d = emit_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          train_d = do_train_i;
          emit_d = do_emit_i;
          state_d = do_fir_i ? ST_FIR : ST_IDLE;
        end
      end
      ST_FIR: if (sts_i.last_tap) state_d = ST_FIRLAST;
      ST_FIRLAST: state_d = train_q ? ST_UPD : (emit_q ? ST_OUT : ST_IDLE);
      ST_UPD: if (sts_i.last_tap) state_d = ST_IDLE;
      ST_OUT: if (out_free_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = (state_q == ST_IDLE);
    accept_o = (state_q == ST_IDLE) && in_valid_i;
    case (state_q)
      ST_IDLE: cmd_o.clear_acc = 1'b1;
      ST_FIR: cmd_o.mac = 1'b1;
      ST_UPD: cmd_o.update = 1'b1;
      ST_OUT: cmd_o.emit = out_free_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      train_q <= 1'b0;
      emit_q <= 1'b0;
    end else begin
      state_q <= state_d;
      train_q <= train_d;
      emit_q <= emit_d;
    end
  end
endmodule

// ----- rtl/core/lte_datapath.sv -----
// ----------------------------------------------------------------------------
// lte_datapath
// Delay line, tap weights, one shared MAC and LMS update unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module lte_datapath import lte_pkg::*; #(
  parameter int NUM_TAPS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               shift_i,
  input  logic signed [15:0] sample_i,
  input  logic [23:0]        step_i,
  input  logic               tgt_zero_i,
  input  logic               tgt_pos_i,
  input  lte_cmd_t           cmd_i,
  output lte_sts_t           sts_o,
  output logic signed [15:0] y_o
);
  localparam int TW = $clog2(NUM_TAPS);
  logic signed [15:0] dl_q [NUM_TAPS];
  logic signed [17:0] w_q [NUM_TAPS];
  logic [TW-1:0] idx_q;
  logic signed [47:0] acc_q;
  logic signed [41:0] be_q;
  logic signed [15:0] y;
  logic signed [47:0] r;
  logic signed [33:0] prod;
  logic signed [58:0] p;
  logic signed [31:0] dw;
  logic signed [32:0] t;
  logic signed [17:0] w_new;
  logic signed [16:0] tgt;
  logic rot;

  // Both arrays rotate by one tap per MAC or update cycle, so tap 0 is always
  // the one being worked on and a full pass leaves them in their original order.
  assign rot = cmd_i.mac || cmd_i.update;

  always_comb begin
    r = (acc_q + 48'sd32768) >>> 16;
    if (r > 48'sd32767) y = 16'sh7fff;
    else if (r < -48'sd32768) y = 16'sh8000;
    else y = r[15:0];
    tgt = tgt_zero_i ? 17'sd0 : (tgt_pos_i ? 17'(LevelQ10) : -17'(LevelQ10));
    prod = dl_q[0] * w_q[0];
    p = be_q * dl_q[0];
    dw = 32'((p + (59'sd1 <<< 27)) >>> 28);
    t = 33'(w_q[0]) - 33'(dw);
    if (t > 33'sd131071) w_new = 18'sh1ffff;
    else if (t < -33'sd131072) w_new = 18'sh20000;
    else w_new = t[17:0];
  end
  assign y_o = y;
  assign sts_o.last_tap = (idx_q == TW'(NUM_TAPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_TAPS; k++) begin
        dl_q[k] <= '0;
        w_q[k] <= '0;
      end
      idx_q <= '0;
      acc_q <= '0;
      be_q <= '0;
    end else begin
      if (shift_i) begin
        for (int k = 0; k < NUM_TAPS - 1; k++) dl_q[k] <= dl_q[k+1];
        dl_q[NUM_TAPS-1] <= sample_i;
      end else if (rot) begin
        for (int k = 0; k < NUM_TAPS - 1; k++) begin
          dl_q[k] <= dl_q[k+1];
          w_q[k] <= w_q[k+1];
        end
        dl_q[NUM_TAPS-1] <= dl_q[0];
        w_q[NUM_TAPS-1] <= cmd_i.update ? w_new : w_q[0];
      end
      if (cmd_i.clear_acc) begin
        acc_q <= '0;
        idx_q <= '0;
      end else begin
        if (cmd_i.mac) acc_q <= acc_q + 48'(prod);
        if (rot) idx_q <= sts_o.last_tap ? '0 : idx_q + 1'b1;
      end
      // After the last tap the accumulator settles; the scaled error is formed next.
      if (!rot && !cmd_i.clear_acc) begin
        be_q <= 42'($signed({1'b0, step_i})) * 42'(17'(y) - tgt);
      end
    end
  end
endmodule

// ----- rtl/core/lms_training_equalizer_unit.sv -----
// One symbol per word. A word that yields an output or a training step is
// accepted, runs through every tap on the shared multiply-accumulate unit, is
// rounded, then either loads the output register (waiting while the previous
// result word is still held) or, for training, steps through every tap again
// updating its weight. Other words are only accepted. No new word is taken
// until the previous one is done.
`timescale 1ns / 1ps
module lms_training_equalizer_unit import lte_pkg::*; #(
  parameter int NUM_TAPS = 64,
  parameter int PRE_TAPS = 20,
  parameter int TRAIN_LENGTH = 704
) (
  input  logic clk_i,
  input  logic rst_ni,
  lte_stream_if.sink   in_if,
  lte_stream_if.sink   cfg_if,
  lte_stream_if.source out_if
);
  localparam int Lookahead = NUM_TAPS - PRE_TAPS - 1;
  logic [23:0] step_q;
  logic [PosW-1:0] pos_q, pos_d;
  logic [10:0] tags_q, tags_d, ptags_q, ptags_d;
  logic primed_q, primed_d, pcomp_q, pcomp_d;
  logic [PosW-1:0] j_q, j_d;
  logic [9:0] otags_q, otags_d;
  logic [8:0] pn9_q, pn9_d, cur9;
  logic [5:0] pn6_q, pn6_d, cur6;
  logic tbit_q, tbit_d;
  logic do_fir, do_train, do_emit, accept;
  lte_cmd_t cmd;
  lte_sts_t sts;
  logic signed [15:0] y;
  logic ov_q;
  logic signed [15:0] oy_q;
  logic [9:0] oseg_q;
  logic olast_q;

  logic [15:0] smp;
  logic sst, fsy, sf;
  logic [8:0] sn;
  assign {smp, sst, fsy, sf, sn} = in_if.data;

  always_comb begin
    pos_d = pos_q; tags_d = tags_q; ptags_d = ptags_q;
    primed_d = primed_q; pcomp_d = pcomp_q;
    if (sst) begin
      pcomp_d = primed_q && pos_q == PosW'(SegmentLength - 1);
      ptags_d = tags_q;
      tags_d = {fsy, sf, sn};
      pos_d = '0;
      primed_d = 1'b1;
    end else if (primed_q) begin
      if (pos_q == PosW'(SegmentLength - 1)) begin
        pcomp_d = 1'b1; ptags_d = tags_q; pos_d = '0;
      end else pos_d = pos_q + 1'b1;
    end
    do_fir = 1'b0; do_train = 1'b0; do_emit = 1'b0;
    j_d = '0; otags_d = tags_d[9:0];
    if (primed_d) begin
      if (pos_d < PosW'(Lookahead)) begin
        j_d = PosW'(SegmentLength - Lookahead) + pos_d;
        otags_d = ptags_d[9:0];
        do_emit = pcomp_d && !ptags_d[10];
      end else begin
        j_d = pos_d - PosW'(Lookahead);
        if (tags_d[10]) do_train = j_d < PosW'(TRAIN_LENGTH);
        else do_emit = 1'b1;
      end
    end
    do_fir = do_emit || do_train;
  end

  // Training positions arrive in order from zero, so each pseudo-noise generator
  // steps once per training word in its own part of the sequence and restarts at position zero.
  always_comb begin
    cur9 = (j_d == '0) ? Pn9Init : pn9_q;
    cur6 = (j_d == '0) ? Pn6Init : pn6_q;
    pn9_d = cur9;
    pn6_d = cur6;
    if (j_d < PosW'(4)) begin
      tbit_d = (j_d == PosW'(0)) || (j_d == PosW'(3));
    end else if (j_d < PosW'(4 + Pn9Len)) begin
      tbit_d = cur9[0];
      pn9_d = {cur9[7] ^ cur9[6] ^ cur9[4] ^ cur9[3] ^ cur9[1] ^ cur9[0], cur9[8:1]};
    end else begin
      tbit_d = cur6[0];
      // The middle PN63 is inverted in field 2.
      if (j_d >= PosW'(4 + Pn9Len + Pn6Len) && j_d < PosW'(4 + Pn9Len + 2 * Pn6Len)) begin
        tbit_d = cur6[0] ^ tags_d[9];
      end
      pn6_d = {cur6[1] ^ cur6[0], cur6[5:1]};
    end
  end

  lte_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .do_fir_i(do_fir), .do_train_i(do_train), .do_emit_i(do_emit),
    .out_free_i(!ov_q || out_if.ready), .sts_i(sts), .cmd_o(cmd), .accept_o(accept)
  );

  lte_datapath #(.NUM_TAPS(NUM_TAPS)) u_dp (
    .clk_i, .rst_ni, .shift_i(accept), .sample_i(smp), .step_i(step_q),
    .tgt_zero_i(j_q >= PosW'(4 + Pn9Len + 3 * Pn6Len)), .tgt_pos_i(tbit_q),
    .cmd_i(cmd), .sts_o(sts), .y_o(y)
  );

  assign cfg_if.ready = 1'b1;
  assign out_if.valid = ov_q;
  assign out_if.data = {oy_q, oseg_q[8:0], oseg_q[9], olast_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 24'd839;
      pos_q <= '0; tags_q <= '0; ptags_q <= '0;
      primed_q <= 1'b0; pcomp_q <= 1'b0;
      j_q <= '0; otags_q <= '0;
      pn9_q <= Pn9Init; pn6_q <= Pn6Init; tbit_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (cfg_if.valid) step_q <= cfg_if.data;
      if (accept) begin
        pos_q <= pos_d; tags_q <= tags_d; ptags_q <= ptags_d;
        primed_q <= primed_d; pcomp_q <= pcomp_d;
        j_q <= j_d; otags_q <= otags_d; tbit_q <= tbit_d;
      end
      if (accept && do_train) begin
        pn9_q <= pn9_d;
        pn6_q <= pn6_d;
      end
      if (cmd.emit) ov_q <= 1'b1;
      else if (out_if.ready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.emit) begin
      oy_q <= y;
      oseg_q <= {otags_q[9], otags_q[8:0]};
      olast_q <= (j_q == PosW'(SegmentLength - 1));
    end
  end
endmodule

// ----- rtl/core/lte_checker.sv -----
// ----------------------------------------------------------------------------
// lte_checker
// Port-level checks of the equalizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lms_training_equalizer_unit_defines.svh"
module lte_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [26:0] out_data
);
  // A symbol word that waits keeps its valid up until it is taken.
  `LTE_ASSERT_NXT(a_in_hold, clk_i, rst_ni, in_valid && !in_ready, in_valid)
  `LTE_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(out_data))
  `LTE_ASSERT_IMP(a_out_known, clk_i, rst_ni, out_valid, !$isunknown(out_data))
  `LTE_ASSERT_IMP(a_seg_range, clk_i, rst_ni, out_valid, out_data[10:2] < 9'd312)
endmodule

bind lms_training_equalizer_unit lte_checker u_chk (
  .clk_i, .rst_ni, .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .out_data(out_if.data)
);

// ----- tb/sv/lte_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// lte_tb_pkg
// Word layouts of the symbol, result and step-size channels used by the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package lte_tb_pkg;
  typedef struct packed {
    logic signed [15:0] sample;
    logic               segment_start;
    logic               field_sync;
    logic               second_field;
    logic [8:0]         segment_number;
  } lte_symbol_t;

  typedef struct packed {
    logic signed [15:0] equalized;
    logic [8:0]         out_segment_number;
    logic               out_second_field;
    logic               last_in_segment;
  } lte_result_t;

  typedef logic [23:0] lte_step_t;

  localparam int NumTaps   = 64;
  localparam int PreTaps   = 20;
  localparam int Lookahead = NumTaps - PreTaps - 1;
  localparam int TrainLen  = 704;
endpackage

// ----- tb/sv/lms_training_equalizer_unit_checker.sv -----
// ----------------------------------------------------------------------------
// lms_training_equalizer_unit_checker
// Watches the symbol, step-size and result channels, runs its own model of the
// adaptive equalizer and compares every result word with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module lms_training_equalizer_unit_checker import lte_pkg::*; import lte_tb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  lte_stream_if in_mon,
  lte_stream_if cfg_mon,
  lte_stream_if out_mon,
  output int    pending_o,
  output int    fail_count_o
);
  logic signed [15:0] taps_line[NumTaps];
  int                 weights[NumTaps];
  longint             beta;
  int                 seg_pos;
  logic [10:0]        cur_tags;
  logic [10:0]        last_tags;
  bit                 in_segment;
  bit                 last_whole;
  bit                 pn9[Pn9Len];
  bit                 pn6[Pn6Len];
  lte_result_t        expected_q[$];
  int                 fails;

  assign pending_o    = expected_q.size();
  assign fail_count_o = fails;

  initial begin
    for (int n = 0; n < Pn9Len; n++) begin
      if (n < 9) pn9[n] = (n == 7);
      else pn9[n] = pn9[n-2] ^ pn9[n-3] ^ pn9[n-5] ^ pn9[n-6] ^ pn9[n-8] ^ pn9[n-9];
    end
    for (int n = 0; n < Pn6Len; n++) begin
      if (n < 6) pn6[n] = (n < 3) || (n == 5);
      else pn6[n] = pn6[n-5] ^ pn6[n-6];
    end
    fails = 0;
  end

  function automatic int filter_sum();
    longint acc;
    acc = 0;
    for (int k = 0; k < NumTaps; k++) acc += longint'(taps_line[k]) * longint'(weights[k]);
    acc = (acc + 32768) >>> 16;
    if (acc > 32767) acc = 32767;
    if (acc < -32768) acc = -32768;
    return int'(acc);
  endfunction

  function automatic int sync_level(int j, bit f2);
    bit b;
    if (j < 4) b = (j == 0 || j == 3);
    else if (j < 4 + Pn9Len) b = pn9[j-4];
    else if (j < 4 + Pn9Len + Pn6Len) b = pn6[j-4-Pn9Len];
    else if (j < 4 + Pn9Len + 2 * Pn6Len) b = pn6[j-4-Pn9Len-Pn6Len] ^ f2;
    else if (j < 4 + Pn9Len + 3 * Pn6Len) b = pn6[j-4-Pn9Len-2*Pn6Len];
    else return 0;
    return b ? LevelQ10 : -LevelQ10;
  endfunction

  task automatic adapt_taps(int j, bit f2);
    longint err;
    longint p;
    longint t;
    err = longint'(filter_sum() - sync_level(j, f2));
    for (int k = 0; k < NumTaps; k++) begin
      p = beta * err * longint'(taps_line[k]);
      t = longint'(weights[k]) - ((p + (longint'(1) << 27)) >>> 28);
      if (t > 131071) t = 131071;
      if (t < -131072) t = -131072;
      weights[k] = int'(t);
    end
  endtask

  task automatic predict_symbol(lte_symbol_t w);
    logic [10:0] tags;
    logic [10:0] use_tags;
    int j;
    lte_result_t r;
    tags = {w.field_sync, w.second_field, w.segment_number};
    for (int k = 0; k < NumTaps - 1; k++) taps_line[k] = taps_line[k+1];
    taps_line[NumTaps-1] = w.sample;
    if (w.segment_start) begin
      last_whole = in_segment && seg_pos == SegmentLength - 1;
      last_tags  = cur_tags;
      cur_tags   = tags;
      seg_pos    = 0;
      in_segment = 1'b1;
    end else if (in_segment) begin
      seg_pos++;
      // A segment that runs past its length restarts with the same tags.
      if (seg_pos >= SegmentLength) begin
        last_whole = 1'b1;
        last_tags  = cur_tags;
        seg_pos    = 0;
      end
    end
    if (!in_segment) return;
    if (seg_pos < Lookahead) begin
      if (!last_whole || last_tags[10]) return;
      j = SegmentLength - Lookahead + seg_pos;
      use_tags = last_tags;
    end else begin
      j = seg_pos - Lookahead;
      if (cur_tags[10]) begin
        if (j < TrainLen) adapt_taps(j, cur_tags[9]);
        return;
      end
      use_tags = cur_tags;
    end
    r.equalized          = 16'(filter_sum());
    r.out_segment_number = use_tags[8:0];
    r.out_second_field   = use_tags[9];
    r.last_in_segment    = (j == SegmentLength - 1);
    expected_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lte_result_t got;
    lte_result_t exp_r;
    if (!rst_ni) begin
      for (int k = 0; k < NumTaps; k++) begin
        taps_line[k] = '0;
        weights[k]   = 0;
      end
      beta       = 839;
      seg_pos    = 0;
      cur_tags   = '0;
      last_tags  = '0;
      in_segment = 1'b0;
      last_whole = 1'b0;
      expected_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) beta = longint'(cfg_mon.data);
      if (in_mon.valid && in_mon.ready) predict_symbol(in_mon.data);
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (expected_q.size() == 0) begin
          $error("unexpected result word: %p", got);
          fails++;
        end else begin
          exp_r = expected_q.pop_front();
          if (got.equalized !== exp_r.equalized) begin
            $error("equalized: expected %0d, got %0d", exp_r.equalized, got.equalized);
            fails++;
          end
          if (got.out_segment_number !== exp_r.out_segment_number) begin
            $error("out_segment_number: expected %0d, got %0d",
                   exp_r.out_segment_number, got.out_segment_number);
            fails++;
          end
          if (got.out_second_field !== exp_r.out_second_field) begin
            $error("out_second_field: expected %0d, got %0d",
                   exp_r.out_second_field, got.out_second_field);
            fails++;
          end
          if (got.last_in_segment !== exp_r.last_in_segment) begin
            $error("last_in_segment: expected %0d, got %0d",
                   exp_r.last_in_segment, got.last_in_segment);
            fails++;
          end
        end
      end
    end
  end
endmodule

// ----- tb/sv/lms_training_equalizer_unit_tb.sv -----
// ----------------------------------------------------------------------------
// lms_training_equalizer_unit_tb
// Drives segments of symbols with random gaps and stalls, changes the step
// size between phases and reports the verdict from the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module lms_training_equalizer_unit_tb import lte_tb_pkg::*;;
  localparam int IdleLimit = 4000;

  logic clk_i;
  logic rst_ni;
  int   pending;
  int   fail_count;
  int   idle_cycles;
  int   stall_left;
  bit   no_gaps;

  lte_stream_if #(.T(lte_symbol_t)) in_if ();
  lte_stream_if #(.T(lte_step_t))   cfg_if ();
  lte_stream_if #(.T(lte_result_t)) out_if ();

  lms_training_equalizer_unit u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if),
    .cfg_if(cfg_if),
    .out_if(out_if)
  );

  lms_training_equalizer_unit_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_if),
    .cfg_mon     (cfg_if),
    .out_mon     (out_if),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Mostly noisy 8-level symbols, with some words over the full range.
  function automatic logic [15:0] pick_sample(int wild_pct);
    int lv;
    if ($urandom_range(99) < wild_pct) return 16'($urandom);
    lv = 2 * int'($urandom_range(7)) - 7;
    return 16'(lv * 1024 + int'($urandom_range(400)) - 200);
  endfunction

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_if.ready <= no_gaps ? 1'b1 : ($urandom_range(3) != 0);
      stall_left   <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_word(logic [15:0] s, bit ss, bit fs, bit f2, logic [8:0] num);
    int gap;
    in_if.valid <= 1'b1;
    in_if.data  <= '{sample: s, segment_start: ss, field_sync: fs,
                     second_field: f2, segment_number: num};
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_segment(int n, bit ss, bit fs, bit f2, logic [8:0] num, int wild_pct);
    for (int i = 0; i < n; i++) send_word(pick_sample(wild_pct), ss && i == 0, fs, f2, num);
  endtask

  task automatic write_step(lte_step_t v);
    in_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    // Words without a result may still be in flight.
    repeat (200) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    out_if.ready = 1'b0;
    stall_left   = 0;
    idle_cycles  = 0;
    no_gaps      = 1'b0;
    rst_ni       = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Words before the first segment start only fill the delay line.
    send_word(16'h7fff, 1'b0, 1'b0, 1'b0, 9'd0);
    send_word(16'h8000, 1'b0, 1'b1, 1'b1, 9'd311);
    send_word(16'h0000, 1'b0, 1'b0, 1'b1, 9'd0);
    send_word(16'hffff, 1'b0, 1'b1, 1'b0, 9'd311);
    send_segment(8, 1'b0, 1'b0, 1'b0, 9'd0, 100);

    // Reset step size: a field-sync segment cut short during training.
    send_segment(250, 1'b1, 1'b1, 1'b0, 9'd0, 5);

    // A data segment whose next start is missing, so it restarts on its own.
    send_segment(880, 1'b1, 1'b0, 1'b0, 9'($urandom_range(311)), 10);

    // Largest step: training in field 2 drives the taps into saturation.
    write_step(24'hffffff);
    send_segment(690, 1'b1, 1'b1, 1'b1, 9'($urandom_range(311)), 30);

    // Back-to-back data words after a training segment cut short.
    no_gaps = 1'b1;
    send_segment(60, 1'b1, 1'b0, 1'b1, 9'd311, 20);
    no_gaps = 1'b0;
    in_if.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/lte_pkg.sv
rtl/core/lte_stream_if.sv
rtl/core/lte_ctrl.sv
rtl/core/lte_datapath.sv
rtl/core/lms_training_equalizer_unit.sv
rtl/core/lte_checker.sv
tb/sv/lte_tb_pkg.sv
tb/sv/lms_training_equalizer_unit_checker.sv
tb/sv/lms_training_equalizer_unit_tb.sv
